/* design/abc_pkg.sv */
// shared types, constants and microcode program for the adaptive backstepping controller
package abc_pkg;

    localparam int AXES    = 3;
    localparam int IN_W    = 32;
    localparam int DRV_W   = 32;
    localparam int DIST_W  = 21;
    localparam int TGT_W   = 20;
    localparam int GAIN_W  = 24;
    localparam int FRAC_W  = 16;
    localparam int SPLIT_W = 24;
    localparam int OPA_W   = IN_W + 1;
    localparam int ACC_W   = OPA_W + GAIN_W + 1;
    localparam int STEP_W  = 4;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [GAIN_W-1:0] RST_POS_GAIN    = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0] RST_VEL_GAIN    = GAIN_W'(131072);
    localparam logic [GAIN_W-1:0] RST_ADAPT_GAIN  = GAIN_W'(32768);
    localparam logic [GAIN_W-1:0] RST_STEP_PERIOD = GAIN_W'(167772);

    localparam logic signed [ACC_W-1:0] DRV_MAX = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] DRV_MIN = -DRV_MAX - 1;
    localparam logic signed [ACC_W-1:0] D_LIMIT = ACC_W'(655360);
    localparam logic signed [ACC_W-1:0] V_LIMIT = ACC_W'(327680);

    typedef enum logic [2:0] {
        A_PE,
        A_VE,
        A_LO16,
        A_HI16,
        A_LO24,
        A_HI24
    } a_sel_t;

    typedef enum logic [1:0] {
        B_K1,
        B_K2,
        B_GAIN,
        B_DT
    } b_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SH16,
        ACC_SH24,
        ACC_DIFF
    } acc_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_DRIVE,
        WR_DIST,
        WR_TGT,
        WR_CLEAR
    } wr_op_t;

    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_BR_CLEAR,
        SQ_JUMP,
        SQ_DONE
    } seq_op_t;

    typedef enum logic [1:0] {
        REG_POS_GAIN,
        REG_VEL_GAIN,
        REG_ADAPT_GAIN,
        REG_STEP_PERIOD
    } reg_idx_t;

    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
        logic    tmp_we;
        wr_op_t  wr_op;
    } lane_ctrl_t;

    typedef struct packed {
        lane_ctrl_t        lane;
        seq_op_t           seq_op;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic [GAIN_W-1:0] k1;
        logic [GAIN_W-1:0] k2;
        logic [GAIN_W-1:0] gain;
        logic [GAIN_W-1:0] dt;
    } gains_t;

    localparam lane_ctrl_t LANE_NOP = '{A_PE, B_K1, ACC_HOLD, 1'b0, WR_NONE};

    localparam logic [STEP_W-1:0] STEP_PUBLISH = STEP_W'(11);
    localparam logic [STEP_W-1:0] STEP_CLEAR   = STEP_W'(12);

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
        ucode_t w;
        w = '{LANE_NOP, SQ_NEXT, '0};
        unique case (addr)
            // k1*pe, branch off for a clear item
            STEP_W'(0):
            begin
                w.lane   = '{A_PE, B_K1, ACC_LOAD, 1'b0, WR_NONE};
                w.seq_op = SQ_BR_CLEAR;
                w.target = STEP_CLEAR;
            end
            // z2 = floor(k1*pe) + ve - dv
            STEP_W'(1):  w.lane = '{A_PE, B_K1, ACC_DIFF, 1'b1, WR_NONE};
            // kz = floor(k2*z2)
            STEP_W'(2):  w.lane = '{A_LO16, B_K2, ACC_LOAD, 1'b0, WR_NONE};
            STEP_W'(3):  w.lane = '{A_HI16, B_K2, ACC_SH16, 1'b0, WR_NONE};
            // drive out, start gain*pe
            STEP_W'(4):  w.lane = '{A_PE, B_GAIN, ACC_LOAD, 1'b1, WR_DRIVE};
            STEP_W'(5):  w.lane = '{A_LO24, B_DT, ACC_LOAD, 1'b0, WR_NONE};
            STEP_W'(6):  w.lane = '{A_HI24, B_DT, ACC_SH24, 1'b0, WR_NONE};
            // disturbance update, start gain*ve
            STEP_W'(7):  w.lane = '{A_VE, B_GAIN, ACC_LOAD, 1'b1, WR_DIST};
            STEP_W'(8):  w.lane = '{A_LO24, B_DT, ACC_LOAD, 1'b0, WR_NONE};
            STEP_W'(9):  w.lane = '{A_HI24, B_DT, ACC_SH24, 1'b0, WR_NONE};
            STEP_W'(10): w.lane = '{A_PE, B_K1, ACC_HOLD, 1'b0, WR_TGT};
            STEP_PUBLISH: w.seq_op = SQ_DONE;
            STEP_CLEAR:
            begin
                w.lane   = '{A_PE, B_K1, ACC_HOLD, 1'b0, WR_CLEAR};
                w.seq_op = SQ_JUMP;
                w.target = STEP_PUBLISH;
            end
            default:
            begin
                w.seq_op = SQ_JUMP;
                w.target = STEP_PUBLISH;
            end
        endcase
        return w;
    endfunction

endpackage

/* design/adaptive_backstepping_control_top.sv */
// top level of the three-axis adaptive backstepping controller
//
// command channel: cmd_valid / cmd_stall with action and per-axis position
// error, velocity error and desired velocity. action 0 runs a control step,
// action 1 clears the drive and the disturbance and target velocity estimates.
// result channel: res_valid / res_stall with per-axis drive and the updated
// estimates; one result per item.
// an accepted item runs the microcode program and its result is registered
// at the publish step (a clear item branches to the clear step first); a new
// item is taken only once the sequencer is idle again. all three axis lanes
// run it in lockstep, each doing at most one multiply-accumulate per step.
// gains and period are to be written over the apb port only while the block
// is idle; the user must keep to this, the block does not enforce it.
// reset clears both estimates and loads the default gains.
// a finished result waits in the output register while res_stall is high;
// the next item is still accepted and worked on, and only its final publish
// step waits until the output register is free.
module adaptive_backstepping_control_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [abc_pkg::ADDR_W-1:0]         paddr,
    input  logic [abc_pkg::DATA_W-1:0]         pwdata,
    output logic [abc_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic                               action,
    input  logic signed [abc_pkg::IN_W-1:0]    pos_err_x,
    input  logic signed [abc_pkg::IN_W-1:0]    pos_err_y,
    input  logic signed [abc_pkg::IN_W-1:0]    pos_err_z,
    input  logic signed [abc_pkg::IN_W-1:0]    vel_err_x,
    input  logic signed [abc_pkg::IN_W-1:0]    vel_err_y,
    input  logic signed [abc_pkg::IN_W-1:0]    vel_err_z,
    input  logic signed [abc_pkg::IN_W-1:0]    want_vel_x,
    input  logic signed [abc_pkg::IN_W-1:0]    want_vel_y,
    input  logic signed [abc_pkg::IN_W-1:0]    want_vel_z,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic signed [abc_pkg::DRV_W-1:0]   drive_x,
    output logic signed [abc_pkg::DRV_W-1:0]   drive_y,
    output logic signed [abc_pkg::DRV_W-1:0]   drive_z,
    output logic signed [abc_pkg::DIST_W-1:0]  dist_est_x,
    output logic signed [abc_pkg::DIST_W-1:0]  dist_est_y,
    output logic signed [abc_pkg::DIST_W-1:0]  dist_est_z,
    output logic signed [abc_pkg::TGT_W-1:0]   tgt_vel_est_x,
    output logic signed [abc_pkg::TGT_W-1:0]   tgt_vel_est_y,
    output logic signed [abc_pkg::TGT_W-1:0]   tgt_vel_est_z
);
    import abc_pkg::*;

    gains_t     gains;
    lane_ctrl_t ctrl;
    logic       busy;
    logic       publish;
    logic       start;
    logic       pub_ok;
    logic       res_valid_reg;
    logic       res_valid_next;

    logic signed [IN_W-1:0]   pe_vec [AXES];
    logic signed [IN_W-1:0]   ve_vec [AXES];
    logic signed [IN_W-1:0]   dv_vec [AXES];
    logic signed [DRV_W-1:0]  drive_w [AXES];
    logic signed [DIST_W-1:0] dist_w [AXES];
    logic signed [TGT_W-1:0]  tgt_w [AXES];
    logic signed [DRV_W-1:0]  drive_out_reg [AXES];
    logic signed [DIST_W-1:0] dist_out_reg [AXES];
    logic signed [TGT_W-1:0]  tgt_out_reg [AXES];

    assign pe_vec[0] = pos_err_x;
    assign pe_vec[1] = pos_err_y;
    assign pe_vec[2] = pos_err_z;
    assign ve_vec[0] = vel_err_x;
    assign ve_vec[1] = vel_err_y;
    assign ve_vec[2] = vel_err_z;
    assign dv_vec[0] = want_vel_x;
    assign dv_vec[1] = want_vel_y;
    assign dv_vec[2] = want_vel_z;

    assign start     = cmd_valid && !busy;
    assign cmd_stall = busy;
    assign pub_ok    = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;

    abc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    abc_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .action  (action),
        .pub_ok  (pub_ok),
        .ctrl    (ctrl),
        .busy    (busy),
        .publish (publish)
    );

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        abc_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (start),
            .pe_in    (pe_vec[g]),
            .ve_in    (ve_vec[g]),
            .dv_in    (dv_vec[g]),
            .ctrl     (ctrl),
            .gains    (gains),
            .drive    (drive_w[g]),
            .dist_est (dist_w[g]),
            .tgt      (tgt_w[g])
        );

        always_ff @(posedge clk)
        begin
            if (publish)
            begin
                drive_out_reg[g] <= drive_w[g];
                dist_out_reg[g]  <= dist_w[g];
                tgt_out_reg[g]   <= tgt_w[g];
            end
        end
    end

    always_comb
    begin
        if (publish)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    assign drive_x       = drive_out_reg[0];
    assign drive_y       = drive_out_reg[1];
    assign drive_z       = drive_out_reg[2];
    assign dist_est_x    = dist_out_reg[0];
    assign dist_est_y    = dist_out_reg[1];
    assign dist_est_z    = dist_out_reg[2];
    assign tgt_vel_est_x = tgt_out_reg[0];
    assign tgt_vel_est_y = tgt_out_reg[1];
    assign tgt_vel_est_z = tgt_out_reg[2];

endmodule

/* design/abc_regs.sv */
// apb configuration registers for the controller gains and period
module abc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [abc_pkg::ADDR_W-1:0]  paddr,
    input  logic [abc_pkg::DATA_W-1:0]  pwdata,
    output logic [abc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output abc_pkg::gains_t             gains
);
    import abc_pkg::*;

    gains_t   gains_reg;
    gains_t   gains_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign gains  = gains_reg;

    always_comb
    begin
        gains_next = gains_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_POS_GAIN:    gains_next.k1   = pwdata[GAIN_W-1:0];
                REG_VEL_GAIN:    gains_next.k2   = pwdata[GAIN_W-1:0];
                REG_ADAPT_GAIN:  gains_next.gain = pwdata[GAIN_W-1:0];
                REG_STEP_PERIOD: gains_next.dt   = pwdata[GAIN_W-1:0];
                default:         gains_next      = gains_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_POS_GAIN:    prdata = DATA_W'(gains_reg.k1);
            REG_VEL_GAIN:    prdata = DATA_W'(gains_reg.k2);
            REG_ADAPT_GAIN:  prdata = DATA_W'(gains_reg.gain);
            REG_STEP_PERIOD: prdata = DATA_W'(gains_reg.dt);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '{RST_POS_GAIN, RST_VEL_GAIN, RST_ADAPT_GAIN, RST_STEP_PERIOD};
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

endmodule

/* design/abc_seq.sv */
// microcode sequencer: step counter, program rom and branch logic
module abc_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                action,
    input  logic                pub_ok,
    output abc_pkg::lane_ctrl_t ctrl,
    output logic                busy,
    output logic                publish
);
    import abc_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic              action_reg;
    logic              action_next;
    ucode_t            uw;

    assign uw      = ucode_rom(step_reg);
    assign busy    = busy_reg;
    assign ctrl    = busy_reg ? uw.lane : LANE_NOP;
    assign publish = busy_reg && (uw.seq_op == SQ_DONE) && pub_ok;

    always_comb
    begin
        step_next   = step_reg;
        busy_next   = busy_reg;
        action_next = action_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next   = 1'b1;
                step_next   = '0;
                action_next = action;
            end
        end
        else
        begin
            unique case (uw.seq_op)
                SQ_NEXT:     step_next = step_reg + STEP_W'(1);
                SQ_BR_CLEAR: step_next = action_reg ? uw.target : step_reg + STEP_W'(1);
                SQ_JUMP:     step_next = uw.target;
                SQ_DONE:
                begin
                    if (pub_ok)
                    begin
                        busy_next = 1'b0;
                        step_next = '0;
                    end
                end
                default:     step_next = uw.target;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            busy_reg   <= 1'b0;
            action_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            busy_reg   <= busy_next;
            action_reg <= action_next;
        end
    end

    a_idle_at_entry: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> step_reg == '0)
        else $error("sequencer idle away from entry step");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy_reg |=> busy_reg && step_reg == '0)
        else $error("start did not enter program");

    a_publish_ends: assert property (@(posedge clk) disable iff (!rst_n)
        publish |=> !busy_reg)
        else $error("sequencer still busy after publish");

endmodule

/* design/abc_lane.sv */
// per-axis datapath: multiplier, accumulator, temp register and estimate stores
module abc_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic signed [abc_pkg::IN_W-1:0]   pe_in,
    input  logic signed [abc_pkg::IN_W-1:0]   ve_in,
    input  logic signed [abc_pkg::IN_W-1:0]   dv_in,
    input  abc_pkg::lane_ctrl_t               ctrl,
    input  abc_pkg::gains_t                   gains,
    output logic signed [abc_pkg::DRV_W-1:0]  drive,
    output logic signed [abc_pkg::DIST_W-1:0] dist_est,
    output logic signed [abc_pkg::TGT_W-1:0]  tgt
);
    import abc_pkg::*;

    logic signed [IN_W-1:0]   pe_reg, pe_next;
    logic signed [IN_W-1:0]   ve_reg, ve_next;
    logic signed [IN_W-1:0]   dv_reg, dv_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  tmp_reg, tmp_next;
    logic signed [DRV_W-1:0]  drive_reg, drive_next;
    logic signed [DIST_W-1:0] dist_reg, dist_next;
    logic signed [TGT_W-1:0]  tgt_reg, tgt_next;

    logic signed [OPA_W-1:0]  opa;
    logic signed [GAIN_W:0]   opb;
    logic signed [ACC_W-1:0]  prod;
    logic signed [IN_W:0]     diff;
    logic signed [ACC_W-1:0]  drv_full;
    logic signed [ACC_W-1:0]  dist_sum;
    logic signed [ACC_W-1:0]  tgt_sum;

    assign drive    = drive_reg;
    assign dist_est = dist_reg;
    assign tgt      = tgt_reg;

    always_comb
    begin
        case (ctrl.a_sel)
            A_PE:    opa = OPA_W'(pe_reg);
            A_VE:    opa = OPA_W'(ve_reg);
            A_LO16:  opa = {{(OPA_W-FRAC_W){1'b0}}, tmp_reg[FRAC_W-1:0]};
            A_HI16:  opa = tmp_reg[FRAC_W +: OPA_W];
            A_LO24:  opa = {{(OPA_W-SPLIT_W){1'b0}}, tmp_reg[SPLIT_W-1:0]};
            A_HI24:  opa = tmp_reg[SPLIT_W +: OPA_W];
            default: opa = '0;
        endcase
        case (ctrl.b_sel)
            B_K1:    opb = {1'b0, gains.k1};
            B_K2:    opb = {1'b0, gains.k2};
            B_GAIN:  opb = {1'b0, gains.gain};
            B_DT:    opb = {1'b0, gains.dt};
            default: opb = '0;
        endcase
    end

    assign prod = opa * opb;
    assign diff = (IN_W+1)'(ve_reg) - (IN_W+1)'(dv_reg);

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_LOAD: acc_next = prod;
            ACC_SH16: acc_next = (acc_reg >>> FRAC_W) + prod;
            ACC_SH24: acc_next = (acc_reg >>> SPLIT_W) + prod;
            ACC_DIFF: acc_next = (acc_reg >>> FRAC_W) + ACC_W'(diff);
            default:  acc_next = acc_reg;
        endcase
        tmp_next = ctrl.tmp_we ? acc_next : tmp_reg;
    end

    assign drv_full = -acc_reg - ACC_W'(pe_reg) - ACC_W'(dist_reg);
    assign dist_sum = ACC_W'(dist_reg) + (acc_reg >>> FRAC_W);
    assign tgt_sum  = ACC_W'(tgt_reg) + (acc_reg >>> FRAC_W);

    always_comb
    begin
        pe_next    = load ? pe_in : pe_reg;
        ve_next    = load ? ve_in : ve_reg;
        dv_next    = load ? dv_in : dv_reg;
        drive_next = drive_reg;
        dist_next  = dist_reg;
        tgt_next   = tgt_reg;
        case (ctrl.wr_op)
            WR_DRIVE:
            begin
                if (drv_full > DRV_MAX)
                    drive_next = DRV_W'(DRV_MAX);
                else if (drv_full < DRV_MIN)
                    drive_next = DRV_W'(DRV_MIN);
                else
                    drive_next = DRV_W'(drv_full);
            end
            WR_DIST:
            begin
                if (dist_sum > D_LIMIT)
                    dist_next = DIST_W'(D_LIMIT);
                else if (dist_sum < -D_LIMIT)
                    dist_next = DIST_W'(-D_LIMIT);
                else
                    dist_next = DIST_W'(dist_sum);
            end
            WR_TGT:
            begin
                if (tgt_sum > V_LIMIT)
                    tgt_next = TGT_W'(V_LIMIT);
                else if (tgt_sum < -V_LIMIT)
                    tgt_next = TGT_W'(-V_LIMIT);
                else
                    tgt_next = TGT_W'(tgt_sum);
            end
            WR_CLEAR:
            begin
                drive_next = '0;
                dist_next  = '0;
                tgt_next   = '0;
            end
            default:
            begin
                drive_next = drive_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pe_reg    <= pe_next;
        ve_reg    <= ve_next;
        dv_reg    <= dv_next;
        acc_reg   <= acc_next;
        tmp_reg   <= tmp_next;
        drive_reg <= drive_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= '0;
            tgt_reg  <= '0;
        end
        else
        begin
            dist_reg <= dist_next;
            tgt_reg  <= tgt_next;
        end
    end

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        dist_reg <= D_LIMIT && dist_reg >= -D_LIMIT)
        else $error("disturbance estimate out of range");

    a_tgt_range: assert property (@(posedge clk) disable iff (!rst_n)
        tgt_reg <= V_LIMIT && tgt_reg >= -V_LIMIT)
        else $error("target velocity estimate out of range");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_op == WR_CLEAR |=> dist_reg == '0 && tgt_reg == '0 && drive_reg == '0)
        else $error("clear left estimates nonzero");

endmodule

/* tb/sv/tb.sv */
// testbench for the three-axis adaptive backstepping controller: directed, gain-corner and random items
module tb;

    typedef logic signed [abc_pkg::IN_W-1:0] q16_t;

    typedef struct {
        logic act;
        q16_t pe[abc_pkg::AXES];
        q16_t ve[abc_pkg::AXES];
        q16_t dv[abc_pkg::AXES];
    } cmd_item_t;

    typedef struct {
        logic signed [abc_pkg::DRV_W-1:0]  drive[abc_pkg::AXES];
        logic signed [abc_pkg::DIST_W-1:0] dist_est[abc_pkg::AXES];
        logic signed [abc_pkg::TGT_W-1:0]  tgt[abc_pkg::AXES];
    } ctrl_result_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN,
        RX_HOLD
    } rx_mode_t;

    localparam q16_t Q_ONE = 32'sh0001_0000;
    localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q_MIN = 32'sh8000_0000;
    localparam logic signed [95:0] DRIVE_HI = 96'sd2147483647;
    localparam logic signed [95:0] DRIVE_LO = -96'sd2147483648;
    localparam logic signed [95:0] DIST_CAP = 96'sd655360;
    localparam logic signed [95:0] TGT_CAP  = 96'sd327680;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int RUN_ITEMS   = 120;
    localparam int DRAIN_WAIT  = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [abc_pkg::ADDR_W-1:0] paddr = '0;
    logic [abc_pkg::DATA_W-1:0] pwdata = '0;
    logic [abc_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    logic action = 1'b0;
    q16_t pos_err_x = '0;
    q16_t pos_err_y = '0;
    q16_t pos_err_z = '0;
    q16_t vel_err_x = '0;
    q16_t vel_err_y = '0;
    q16_t vel_err_z = '0;
    q16_t want_vel_x = '0;
    q16_t want_vel_y = '0;
    q16_t want_vel_z = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic signed [abc_pkg::DRV_W-1:0]  drive_x, drive_y, drive_z;
    logic signed [abc_pkg::DIST_W-1:0] dist_est_x, dist_est_y, dist_est_z;
    logic signed [abc_pkg::TGT_W-1:0]  tgt_vel_est_x, tgt_vel_est_y, tgt_vel_est_z;

    abc_pkg::gains_t gain_cfg = '{abc_pkg::RST_POS_GAIN, abc_pkg::RST_VEL_GAIN,
                                  abc_pkg::RST_ADAPT_GAIN, abc_pkg::RST_STEP_PERIOD};
    logic signed [abc_pkg::DIST_W-1:0] dist_st[abc_pkg::AXES] = '{default: '0};
    logic signed [abc_pkg::TGT_W-1:0]  tgt_st[abc_pkg::AXES] = '{default: '0};
    ctrl_result_t expect_q[$];
    string axis_tag[abc_pkg::AXES] = '{"x", "y", "z"};

    rx_mode_t rx_mode = RX_FREE;
    int rx_cycle = 0;
    int hold_cnt = 0;
    int idle_cycles = 0;
    int fail_count = 0;
    int steps_sent = 0;
    int clears_sent = 0;
    int results_checked = 0;
    int settings_used = 0;
    int burst_left = 0;
    bit pace_on = 1'b0;

    adaptive_backstepping_control_top DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [95:0] clip(input logic signed [95:0] x,
                                                 input logic signed [95:0] lo,
                                                 input logic signed [95:0] hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // one control step or clear item on all axes, updates the local copy of the estimates
    function automatic void predict_step(input cmd_item_t it, output ctrl_result_t r);
        logic signed [95:0] pe, ve, dv, k1, k2, ga, dt, d, z2, u, w;
        k1 = {72'd0, gain_cfg.k1};
        k2 = {72'd0, gain_cfg.k2};
        ga = {72'd0, gain_cfg.gain};
        dt = {72'd0, gain_cfg.dt};
        for (int a = 0; a < abc_pkg::AXES; a++)
        begin
            r.drive[a] = '0;
            if (it.act)
            begin
                dist_st[a] = '0;
                tgt_st[a] = '0;
            end
            else
            begin
                pe = it.pe[a];
                ve = it.ve[a];
                dv = it.dv[a];
                d = dist_st[a];
                z2 = (((ve - dv) <<< 16) + k1 * pe) >>> 16;
                u = clip(-((k2 * z2) >>> 16) - pe - d, DRIVE_LO, DRIVE_HI);
                r.drive[a] = u[abc_pkg::DRV_W-1:0];
                w = clip(d + ((ga * pe * dt) >>> 40), -DIST_CAP, DIST_CAP);
                dist_st[a] = w[abc_pkg::DIST_W-1:0];
                w = tgt_st[a];
                w = clip(w + ((ga * ve * dt) >>> 40), -TGT_CAP, TGT_CAP);
                tgt_st[a] = w[abc_pkg::TGT_W-1:0];
            end
            r.dist_est[a] = dist_st[a];
            r.tgt[a] = tgt_st[a];
        end
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    function automatic cmd_item_t make_item(input logic act, input q16_t p, input q16_t v,
                                            input q16_t w);
        cmd_item_t it;
        it.act = act;
        for (int a = 0; a < abc_pkg::AXES; a++)
        begin
            it.pe[a] = p;
            it.ve[a] = v;
            it.dv[a] = w;
        end
        return it;
    endfunction

    function automatic q16_t rand_word();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return -1;
                    default: return Q_ONE;
                endcase
            end
            1, 2, 3: return $urandom();
            default: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        endcase
    endfunction

    function automatic cmd_item_t random_item(input logic act);
        cmd_item_t it;
        it.act = act;
        for (int a = 0; a < abc_pkg::AXES; a++)
        begin
            it.pe[a] = rand_word();
            it.ve[a] = rand_word();
            it.dv[a] = rand_word();
        end
        return it;
    endfunction

    task automatic send_cmd(input cmd_item_t it);
        ctrl_result_t want;
        action <= it.act;
        pos_err_x <= it.pe[0];
        pos_err_y <= it.pe[1];
        pos_err_z <= it.pe[2];
        vel_err_x <= it.ve[0];
        vel_err_y <= it.ve[1];
        vel_err_z <= it.ve[2];
        want_vel_x <= it.dv[0];
        want_vel_y <= it.dv[1];
        want_vel_z <= it.dv[2];
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_step(it, want);
        expect_q.push_back(want);
        if (it.act)
            clears_sent++;
        else
            steps_sent++;
        if (pace_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                burst_left = $urandom_range(0, 12);
            end
        end
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (expect_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic read_reg(input abc_pkg::reg_idx_t idx);
        logic [abc_pkg::DATA_W-1:0] rd;
        logic [abc_pkg::GAIN_W-1:0] want;
        case (idx)
            abc_pkg::REG_POS_GAIN:   want = gain_cfg.k1;
            abc_pkg::REG_VEL_GAIN:   want = gain_cfg.k2;
            abc_pkg::REG_ADAPT_GAIN: want = gain_cfg.gain;
            default:                 want = gain_cfg.dt;
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        check_field($sformatf("register %s", idx.name()), want, rd[abc_pkg::GAIN_W-1:0]);
    endtask

    task automatic write_reg(input abc_pkg::reg_idx_t idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        // bits above the 24-bit register are dropped
        case (idx)
            abc_pkg::REG_POS_GAIN:   gain_cfg.k1 = data[abc_pkg::GAIN_W-1:0];
            abc_pkg::REG_VEL_GAIN:   gain_cfg.k2 = data[abc_pkg::GAIN_W-1:0];
            abc_pkg::REG_ADAPT_GAIN: gain_cfg.gain = data[abc_pkg::GAIN_W-1:0];
            default:                 gain_cfg.dt = data[abc_pkg::GAIN_W-1:0];
        endcase
        read_reg(idx);
    endtask

    task automatic apply_gains(input logic [23:0] k1, input logic [23:0] k2,
                               input logic [23:0] ga, input logic [23:0] dt);
        write_reg(abc_pkg::REG_POS_GAIN, {8'($urandom()), k1});
        write_reg(abc_pkg::REG_VEL_GAIN, {8'($urandom()), k2});
        write_reg(abc_pkg::REG_ADAPT_GAIN, {8'($urandom()), ga});
        write_reg(abc_pkg::REG_STEP_PERIOD, {8'($urandom()), dt});
        settings_used++;
    endtask

    task automatic test_reset_defaults();
        for (int i = 0; i < 4; i++)
            read_reg(abc_pkg::reg_idx_t'(i));
        settings_used++;
    endtask

    task automatic test_directed_steps();
        cmd_item_t it;
        pace_on = 1'b0;
        send_cmd(make_item(1'b0, '0, '0, '0));
        send_cmd(make_item(1'b0, Q_MAX, '0, '0));
        send_cmd(make_item(1'b0, Q_MIN, '0, '0));
        send_cmd(make_item(1'b0, '0, Q_MAX, Q_MIN));
        send_cmd(make_item(1'b0, '0, Q_MIN, Q_MAX));
        send_cmd(make_item(1'b1, Q_MAX, Q_MAX, Q_MAX));
        send_cmd(make_item(1'b0, -1, -1, -1));
        send_cmd(make_item(1'b0, 1, 1, Q_ONE));
        // axes pulled in opposite directions
        it = make_item(1'b0, Q_MAX, Q_MIN, '0);
        it.pe[1] = Q_MIN;
        it.ve[1] = Q_MAX;
        it.pe[2] = '0;
        it.ve[2] = '0;
        send_cmd(it);
        send_cmd(make_item(1'b0, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555));
        send_cmd(make_item(1'b0, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA));
        repeat (3) send_cmd(make_item(1'b0, 5 * Q_ONE, -2 * Q_ONE, Q_ONE));
        send_cmd(make_item(1'b1, '0, '0, '0));
        send_cmd(make_item(1'b0, -3 * Q_ONE, Q_ONE / 2, -Q_ONE));
        wait_drained();
    endtask

    task automatic test_gain_extremes();
        pace_on = 1'b0;
        apply_gains('0, '0, '0, '0);
        send_cmd(make_item(1'b0, Q_MAX, Q_MIN, Q_MAX));
        send_cmd(make_item(1'b0, Q_MIN, Q_MAX, Q_MIN));
        send_cmd(make_item(1'b0, Q_ONE, Q_ONE, -Q_ONE));
        send_cmd(make_item(1'b0, -Q_ONE, 3 * Q_ONE, Q_ONE));
        wait_drained();
        apply_gains('1, '1, '1, '1);
        send_cmd(make_item(1'b0, Q_MAX, Q_MAX, Q_MIN));
        send_cmd(make_item(1'b0, Q_MIN, Q_MIN, Q_MAX));
        send_cmd(make_item(1'b0, 1, -1, 0));
        send_cmd(make_item(1'b0, Q_ONE, Q_ONE, Q_ONE));
        send_cmd(make_item(1'b1, '0, '0, '0));
        send_cmd(make_item(1'b0, -Q_ONE, -Q_ONE, 2 * Q_ONE));
        wait_drained();
    endtask

    task automatic test_random_runs();
        cmd_item_t traj;
        int done;
        int pick;
        int len;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1, 4:
                    apply_gains(24'($urandom()), 24'($urandom()), 24'($urandom()),
                                24'($urandom()));
                2:
                    apply_gains(24'($urandom_range(0, 131072)), 24'($urandom_range(0, 131072)),
                                '1, '1);
                5:
                    apply_gains(abc_pkg::RST_POS_GAIN, abc_pkg::RST_VEL_GAIN,
                                abc_pkg::RST_ADAPT_GAIN, abc_pkg::RST_STEP_PERIOD);
                default:
                    apply_gains(24'($urandom_range(32768, 262144)),
                                24'($urandom_range(32768, 524288)),
                                24'($urandom_range(6554, 262144)),
                                24'($urandom_range(16777, 838861)));
            endcase
            case (ph % 3)
                0: rx_mode <= RX_RANDOM;
                1: rx_mode <= RX_PATTERN;
                default: rx_mode <= RX_FREE;
            endcase
            pace_on = (ph % 2 == 0);
            done = 0;
            while (done < RUN_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                begin
                    send_cmd(random_item(1'b1));
                    done++;
                end
                else if (pick < 20)
                begin
                    send_cmd(random_item(1'b0));
                    done++;
                end
                else
                begin
                    // slowly drifting errors so the estimates build up
                    traj = random_item(1'b0);
                    len = $urandom_range(6, 24);
                    for (int s = 0; s < len && done < RUN_ITEMS; s++)
                    begin
                        for (int a = 0; a < abc_pkg::AXES; a++)
                        begin
                            traj.pe[a] += $signed($urandom_range(0, 8191)) - 4096;
                            traj.ve[a] += $signed($urandom_range(0, 8191)) - 4096;
                            traj.dv[a] += $signed($urandom_range(0, 8191)) - 4096;
                        end
                        send_cmd(traj);
                        done++;
                    end
                end
            end
            wait_drained();
        end
    endtask

    task automatic test_input_backpressure();
        pace_on = 1'b0;
        rx_mode <= RX_HOLD;
        repeat (16) send_cmd(random_item(1'b0));
        wait_drained();
        rx_mode <= RX_FREE;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        hold_cnt <= (rx_mode == RX_HOLD) ? hold_cnt + 1 : 0;
        case (rx_mode)
            RX_RANDOM:  res_stall <= ($urandom_range(0, 99) < 35);
            RX_PATTERN: res_stall <= ((rx_cycle % 11) < 4);
            RX_HOLD:    res_stall <= (hold_cnt < HOLD_CYCLES);
            default:    res_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin : result_check
        ctrl_result_t want, got;
        if (rst_n && res_valid && !res_stall)
        begin
            got.drive = '{drive_x, drive_y, drive_z};
            got.dist_est = '{dist_est_x, dist_est_y, dist_est_z};
            got.tgt = '{tgt_vel_est_x, tgt_vel_est_y, tgt_vel_est_z};
            if (expect_q.size() == 0)
            begin
                $error("result with no item pending");
                fail_count++;
            end
            else
            begin
                want = expect_q.pop_front();
                results_checked++;
                for (int a = 0; a < abc_pkg::AXES; a++)
                begin
                    check_field({"drive_", axis_tag[a]}, want.drive[a], got.drive[a]);
                    check_field({"dist_est_", axis_tag[a]}, want.dist_est[a],
                                got.dist_est[a]);
                    check_field({"tgt_vel_est_", axis_tag[a]}, want.tgt[a], got.tgt[a]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_steps();
        test_gain_extremes();
        test_random_runs();
        test_input_backpressure();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expect_q.size() != 0)
        begin
            $error("%0d results never arrived", expect_q.size());
            fail_count++;
        end
        $display("sent %0d control steps and %0d clears under %0d gain settings",
                 steps_sent, clears_sent, settings_used);
        $display("checked %0d results, incl. a %0d-cycle output hold-off",
                 results_checked, HOLD_CYCLES);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
